// ===== rtl/core/tfn_pkg.sv =====
// shared widths, defaults and sideband type for the face normal pipeline
package tfn_pkg;

	localparam int NORMAL_FRAC_BITS_DEF = 14;
	localparam int CRD_W  = 16;                 // corner coordinate width
	localparam int EDGE_W = CRD_W + 1;          // edge difference width
	localparam int PROD_W = 2 * EDGE_W;         // edge product width
	localparam int MAG_W  = PROD_W;             // cross magnitude width
	localparam int NRM_W  = 30;                 // normalized magnitude, msb lands at bit 29
	localparam int POS_W  = $clog2(MAG_W);      // leading one position width
	localparam int SQ_W   = 2 * NRM_W;          // one square
	localparam int L2_W   = SQ_W + 2;           // sum of three squares
	localparam int LEN_W  = L2_W / 2;           // floor sqrt of sum
	localparam int OUT_W  = 16;                 // normal component width
	localparam int TAG_W  = 16;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic             last;
		logic [2:0]       neg;
		logic             degen;
	} tfn_side_t;

endpackage

// ===== rtl/core/tfn_cross.sv =====
// edges, edge products and cross product magnitudes (three stages)
module tfn_cross (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [2:0][tfn_pkg::CRD_W-1:0]       a,
	input  logic [2:0][tfn_pkg::CRD_W-1:0]       b,
	input  logic [2:0][tfn_pkg::CRD_W-1:0]       c,
	input  logic [tfn_pkg::TAG_W-1:0]            tag,
	input  logic                                 last,
	output logic                                 out_valid,
	output logic [2:0][tfn_pkg::MAG_W-1:0]       mag,
	output tfn_pkg::tfn_side_t                   side
);
	import tfn_pkg::*;

	logic                     vld_s1, vld_s2, vld_s3;
	logic signed [EDGE_W-1:0] e1_s1 [3];
	logic signed [EDGE_W-1:0] e2_s1 [3];
	logic signed [PROD_W-1:0] p_s2 [6];
	logic [TAG_W-1:0]         tag_s1, tag_s2;
	logic                     last_s1, last_s2;
	tfn_side_t                side_s3;
	logic [2:0][MAG_W-1:0]    mag_s3;
	logic signed [PROD_W:0]   d [3];
	logic signed [PROD_W:0]   nd [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_comb begin
		d[0] = p_s2[0] - p_s2[1];
		d[1] = p_s2[2] - p_s2[3];
		d[2] = p_s2[4] - p_s2[5];
		for (int i = 0; i < 3; i++) begin
			nd[i] = -d[i];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				e1_s1[i] <= {b[i][CRD_W-1], b[i]} - {a[i][CRD_W-1], a[i]};
				e2_s1[i] <= {c[i][CRD_W-1], c[i]} - {a[i][CRD_W-1], a[i]};
			end
			tag_s1  <= tag;
			last_s1 <= last;
			p_s2[0] <= e1_s1[1] * e2_s1[2];
			p_s2[1] <= e1_s1[2] * e2_s1[1];
			p_s2[2] <= e1_s1[2] * e2_s1[0];
			p_s2[3] <= e1_s1[0] * e2_s1[2];
			p_s2[4] <= e1_s1[0] * e2_s1[1];
			p_s2[5] <= e1_s1[1] * e2_s1[0];
			tag_s2  <= tag_s1;
			last_s2 <= last_s1;
			for (int i = 0; i < 3; i++) begin
				side_s3.neg[i] <= d[i][PROD_W];
				mag_s3[i]      <= d[i][PROD_W] ? nd[i][MAG_W-1:0] : d[i][MAG_W-1:0];
			end
			side_s3.tag   <= tag_s2;
			side_s3.last  <= last_s2;
			side_s3.degen <= 1'b0;
		end
	end

	assign out_valid = vld_s3;
	assign mag       = mag_s3;
	assign side      = side_s3;

endmodule

// ===== rtl/core/tfn_norm.sv =====
// leading one search, common shift, squares and their sum (four stages)
module tfn_norm (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [2:0][tfn_pkg::MAG_W-1:0]       mag,
	input  tfn_pkg::tfn_side_t                   side,
	output logic                                 out_valid,
	output logic [2:0][tfn_pkg::NRM_W-1:0]       nmag,
	output logic [tfn_pkg::L2_W-1:0]             l2,
	output tfn_pkg::tfn_side_t                   side_out
);
	import tfn_pkg::*;

	localparam int SH_W = MAG_W + NRM_W - 1;

	logic                  vld_s1, vld_s2, vld_s3, vld_s4;
	logic [MAG_W-1:0]      or_v;
	logic [POS_W-1:0]      pos;
	tfn_side_t             side_d;
	logic [2:0][MAG_W-1:0] mag_s1;
	logic [POS_W-1:0]      pos_s1;
	logic [2:0][NRM_W-1:0] mag_s2, mag_s3, mag_s4;
	logic [SQ_W-1:0]       sq_s3 [3];
	logic [L2_W-1:0]       l2_s4;
	logic [SH_W-1:0]       sh [3];
	tfn_side_t             side_s1, side_s2, side_s3, side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	// msb of the largest magnitude is the msb of the or of all three
	always_comb begin
		or_v = mag[0] | mag[1] | mag[2];
		pos  = '0;
		for (int j = 0; j < MAG_W; j++) begin
			if (or_v[j]) pos = POS_W'(j);
		end
		side_d       = side;
		side_d.degen = (or_v == '0);
	end

	// shifting left by msb target then right by msb position truncates like the model
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh[i] = {mag_s1[i], {(NRM_W-1){1'b0}}} >> pos_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1  <= mag;
			pos_s1  <= pos;
			side_s1 <= side_d;
			for (int i = 0; i < 3; i++) begin
				mag_s2[i] <= sh[i][NRM_W-1:0];
				sq_s3[i]  <= mag_s2[i] * mag_s2[i];
			end
			side_s2 <= side_s1;
			mag_s3  <= mag_s2;
			side_s3 <= side_s2;
			l2_s4   <= L2_W'(sq_s3[0]) + L2_W'(sq_s3[1]) + L2_W'(sq_s3[2]);
			mag_s4  <= mag_s3;
			side_s4 <= side_s3;
		end
	end

	assign out_valid = vld_s4;
	assign nmag      = mag_s4;
	assign l2        = l2_s4;
	assign side_out  = side_s4;

endmodule

// ===== rtl/core/tfn_sqrt.sv =====
// pipelined integer square root, two root bits per stage
module tfn_sqrt (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [tfn_pkg::L2_W-1:0]             l2,
	input  logic [2:0][tfn_pkg::NRM_W-1:0]       nmag,
	input  tfn_pkg::tfn_side_t                   side,
	output logic                                 out_valid,
	output logic [tfn_pkg::LEN_W-1:0]            len,
	output logic [2:0][tfn_pkg::NRM_W-1:0]       nmag_out,
	output tfn_pkg::tfn_side_t                   side_out
);
	import tfn_pkg::*;

	localparam int RT_W = LEN_W + 1;        // root register, top bit stays zero
	localparam int RD_W = 2 * RT_W;         // padded radicand
	localparam int RM_W = RT_W + 2;         // partial remainder
	localparam int NS   = RT_W / 2;

	logic                  vld_s [NS+1];
	logic [RD_W-1:0]       rad_s [NS+1];
	logic [RM_W-1:0]       rem_s [NS+1];
	logic [RT_W-1:0]       root_s [NS+1];
	logic [2:0][NRM_W-1:0] mag_s [NS+1];
	tfn_side_t             side_s [NS+1];

	assign vld_s[0]  = in_valid;
	assign rad_s[0]  = RD_W'(l2);
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign mag_s[0]  = nmag;
	assign side_s[0] = side;

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [RD_W-1:0] r;
		logic [RM_W-1:0] rm;
		logic [RM_W-1:0] trial;
		logic [RT_W-1:0] rt;

		always_comb begin
			r  = rad_s[g];
			rm = rem_s[g];
			rt = root_s[g];
			trial = '0;
			for (int k = 0; k < 2; k++) begin
				rm    = {rm[RM_W-3:0], r[RD_W-1 -: 2]};
				r     = r << 2;
				trial = {rt, 2'b01};
				if (rm >= trial) begin
					rm = rm - trial;
					rt = {rt[RT_W-2:0], 1'b1};
				end else begin
					rt = {rt[RT_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g+1]  <= r;
				rem_s[g+1]  <= rm;
				root_s[g+1] <= rt;
				mag_s[g+1]  <= mag_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_valid = vld_s[NS];
	assign len       = root_s[NS][LEN_W-1:0];
	assign nmag_out  = mag_s[NS];
	assign side_out  = side_s[NS];

endmodule

// ===== rtl/core/tfn_div.sv =====
// three lane pipelined rounding divider, two quotient bits per stage
module tfn_div #(
	parameter int NFB = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 in_valid,
	input  logic [tfn_pkg::LEN_W-1:0]            len,
	input  logic [2:0][tfn_pkg::NRM_W-1:0]       nmag,
	input  tfn_pkg::tfn_side_t                   side,
	output logic                                 out_valid,
	output logic [2:0][2*((NFB+2)/2)-1:0]        quo,
	output tfn_pkg::tfn_side_t                   side_out
);
	import tfn_pkg::*;

	localparam int NS   = (NFB + 2) / 2;
	localparam int QP   = 2 * NS;
	localparam int NW   = NRM_W + NFB + 1;
	localparam int RW   = LEN_W + 1;

	logic                 vld_s [NS+1];
	logic [LEN_W-1:0]     len_s [NS+1];
	logic [2:0][RW-1:0]   rem_s [NS+1];
	logic [2:0][QP-1:0]   lo_s [NS+1];
	logic [2:0][QP-1:0]   q_s [NS+1];
	tfn_side_t            side_s [NS+1];
	logic [NW-1:0]        num [3];

	// numerator carries the half-divisor for round half up
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			num[i]      = (NW'(nmag[i]) << NFB) + NW'(len >> 1);
			rem_s[0][i] = RW'(num[i] >> QP);
			lo_s[0][i]  = num[i][QP-1:0];
			q_s[0][i]   = '0;
		end
	end

	assign vld_s[0]  = in_valid;
	assign len_s[0]  = len;
	assign side_s[0] = side;

	for (genvar g = 0; g < NS; g++) begin : g_stage
		logic [2:0][RW-1:0] rm;
		logic [2:0][QP-1:0] lo;
		logic [2:0][QP-1:0] q;

		always_comb begin
			rm = rem_s[g];
			lo = lo_s[g];
			q  = q_s[g];
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 2; k++) begin
					rm[i] = {rm[i][RW-2:0], lo[i][QP-1]};
					lo[i] = lo[i] << 1;
					if (rm[i] >= RW'(len_s[g])) begin
						rm[i] = rm[i] - RW'(len_s[g]);
						q[i]  = {q[i][QP-2:0], 1'b1};
					end else begin
						q[i]  = {q[i][QP-2:0], 1'b0};
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				len_s[g+1]  <= len_s[g];
				rem_s[g+1]  <= rm;
				lo_s[g+1]   <= lo;
				q_s[g+1]    <= q;
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_valid = vld_s[NS];
	assign quo       = q_s[NS];
	assign side_out  = side_s[NS];

endmodule

// ===== rtl/core/triangle_face_normal.sv =====
// throughput: one triangle per cycle while the output is not stalled, every stage is a pipeline register
// sqrt pipe (16 stages) and the divider lanes (two quotient bits a stage) set the depth
// a stalled output holds the whole pipe, nothing is dropped or repeated
// reset: asynchronous active low, clears only the stage valid bits
// top level: unit face normal of a triangle from its three corners
module triangle_face_normal #(
	parameter int NORMAL_FRAC_BITS = tfn_pkg::NORMAL_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// face_tag, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (16 bits each, from bit 0)
	input  logic [159:0] s_axis_tdata,
	input  logic         s_axis_tlast,   // last_face
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// face_tag_out, normal_x, normal_y, normal_z (16 bits each, from bit 0)
	output logic [63:0]  m_axis_tdata,
	output logic         m_axis_tuser,   // degenerate
	output logic         m_axis_tlast    // last_face_out
);
	import tfn_pkg::*;

	localparam int QP = 2 * ((NORMAL_FRAC_BITS + 2) / 2);

	logic                  en;
	logic [2:0][CRD_W-1:0] a, b, c;

	// front end outputs
	logic                  cr_vld;
	logic [2:0][MAG_W-1:0] cr_mag;
	tfn_side_t             cr_side;

	// normalize outputs
	logic                  nm_vld;
	logic [2:0][NRM_W-1:0] nm_mag;
	logic [L2_W-1:0]       nm_l2;
	tfn_side_t             nm_side;

	// sqrt outputs
	logic                  sq_vld;
	logic [LEN_W-1:0]      sq_len;
	logic [2:0][NRM_W-1:0] sq_mag;
	tfn_side_t             sq_side;

	// divider outputs
	logic                  dv_vld;
	logic [2:0][QP-1:0]    dv_q;
	tfn_side_t             dv_side;

	logic                  vld_q;
	logic [2:0][OUT_W-1:0] nrm_q;
	logic [2:0][OUT_W-1:0] nrm_d;
	tfn_side_t             side_q;

	// whole pipe advances unless the output beat is stuck
	assign en            = !vld_q || m_axis_tready;
	assign s_axis_tready = en;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			a[i] = s_axis_tdata[16 + 16*i +: 16];
			b[i] = s_axis_tdata[64 + 16*i +: 16];
			c[i] = s_axis_tdata[112 + 16*i +: 16];
		end
	end

	tfn_cross u_cross (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.a         (a),
		.b         (b),
		.c         (c),
		.tag       (s_axis_tdata[15:0]),
		.last      (s_axis_tlast),
		.out_valid (cr_vld),
		.mag       (cr_mag),
		.side      (cr_side)
	);

	tfn_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (cr_vld),
		.mag       (cr_mag),
		.side      (cr_side),
		.out_valid (nm_vld),
		.nmag      (nm_mag),
		.l2        (nm_l2),
		.side_out  (nm_side)
	);

	tfn_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (nm_vld),
		.l2        (nm_l2),
		.nmag      (nm_mag),
		.side      (nm_side),
		.out_valid (sq_vld),
		.len       (sq_len),
		.nmag_out  (sq_mag),
		.side_out  (sq_side)
	);

	tfn_div #(
		.NFB (NORMAL_FRAC_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_vld),
		.len       (sq_len),
		.nmag      (sq_mag),
		.side      (sq_side),
		.out_valid (dv_vld),
		.quo       (dv_q),
		.side_out  (dv_side)
	);

	// sign, saturate to 16 bits, zero on a degenerate face
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (dv_side.degen) begin
				nrm_d[i] = '0;
			end else if (dv_side.neg[i]) begin
				if (32'(dv_q[i]) > 32'd32768) begin
					nrm_d[i] = 16'h8000;
				end else begin
					nrm_d[i] = 16'(~32'(dv_q[i]) + 32'd1);
				end
			end else begin
				if (32'(dv_q[i]) > 32'd32767) begin
					nrm_d[i] = 16'h7fff;
				end else begin
					nrm_d[i] = 16'(dv_q[i]);
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nrm_q  <= nrm_d;
			side_q <= dv_side;
		end
	end

	assign m_axis_tvalid = vld_q;
	assign m_axis_tdata  = {nrm_q[2], nrm_q[1], nrm_q[0], side_q.tag};
	assign m_axis_tuser  = side_q.degen;
	assign m_axis_tlast  = side_q.last;

endmodule

// ===== tb/tb.sv =====
// testbench for the triangle face normal pipeline
`timescale 1ns / 1ps

module tb;

	localparam int NFRAC     = 14;
	localparam int N_RANDOM  = 1900;
	localparam int LATENCY   = 32;
	localparam longint LIMIT = 400000;

	typedef struct packed {
		logic [15:0] tag;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [15:0] nz;
		logic        degen;
		logic        last;
	} normal_t;

	// one row of the directed table, chk marks a typed-in expectation
	typedef struct {
		logic [159:0] data;
		logic         last;
		bit           chk;
		normal_t      want;
	} face_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [159:0] s_axis_tdata;
	logic         s_axis_tlast;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;
	logic         m_axis_tuser;
	logic         m_axis_tlast;

	normal_t   normal_q[$];
	face_row_t rows[$];
	int        n_err;
	int        n_out;
	int        n_degen;
	int        n_in;
	longint    cyc = 0;
	bit        hold_rx;

	triangle_face_normal #(.NORMAL_FRAC_BITS(NFRAC)) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// bit-serial floor square root
	function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// unit normal of the face packed in d
	function automatic normal_t face_normal(input logic [159:0] d, input logic lst);
		normal_t     o;
		longint      e1[3];
		longint      e2[3];
		longint      cr[3];
		logic [63:0] mg[3];
		logic [63:0] m;
		logic [63:0] l2;
		logic [63:0] len;
		logic [63:0] q;
		longint      s;
		o.tag = d[15:0];
		o.last = lst;
		for (int i = 0; i < 3; i++) begin
			e1[i] = longint'($signed(d[16*(4+i) +: 16])) - longint'($signed(d[16*(1+i) +: 16]));
			e2[i] = longint'($signed(d[16*(7+i) +: 16])) - longint'($signed(d[16*(1+i) +: 16]));
		end
		cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
		cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
		cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
		m = 0;
		for (int i = 0; i < 3; i++) begin
			mg[i] = (cr[i] < 0) ? -cr[i] : cr[i];
			if (mg[i] > m) m = mg[i];
		end
		if (m == 0) begin
			o.nx = 0;
			o.ny = 0;
			o.nz = 0;
			o.degen = 1'b1;
			return o;
		end
		while (m >= (64'd1 << 30)) begin
			m = m >> 1;
			for (int i = 0; i < 3; i++) mg[i] = mg[i] >> 1;
		end
		while (m < (64'd1 << 29)) begin
			m = m << 1;
			for (int i = 0; i < 3; i++) mg[i] = mg[i] << 1;
		end
		l2 = mg[0] * mg[0] + mg[1] * mg[1] + mg[2] * mg[2];
		len = floor_sqrt(l2);
		for (int i = 0; i < 3; i++) begin
			q = ((mg[i] << NFRAC) + (len >> 1)) / len;
			s = (cr[i] < 0) ? -longint'(q) : longint'(q);
			if (s > 32767) s = 32767;
			if (s < -32768) s = -32768;
			if (i == 0) o.nx = s[15:0];
			if (i == 1) o.ny = s[15:0];
			if (i == 2) o.nz = s[15:0];
		end
		o.degen = 1'b0;
		return o;
	endfunction

	function automatic logic [159:0] pack_face(input logic [15:0] tag,
			input logic [15:0] ax, input logic [15:0] ay, input logic [15:0] az,
			input logic [15:0] bx, input logic [15:0] by, input logic [15:0] bz,
			input logic [15:0] cx, input logic [15:0] cy, input logic [15:0] cz);
		return {cz, cy, cx, bz, by, bx, az, ay, ax, tag};
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic [15:0] rand_coord();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 16'h8000;
		if (r == 1) return 16'h7fff;
		if (r < 5) return 16'(int'($urandom_range(0, 255)) - 128);
		return 16'($urandom());
	endfunction

	task automatic add_row(input logic [159:0] d, input logic lst, input bit chk,
			input normal_t want);
		face_row_t r;
		r.data = d;
		r.last = lst;
		r.chk = chk;
		r.want = want;
		rows.push_back(r);
	endtask

	// drive one beat and wait until it is taken
	task automatic send_face(input logic [159:0] d, input logic lst);
		s_axis_tdata <= d;
		s_axis_tlast <= lst;
		s_axis_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		n_in++;
	endtask

	task automatic idle_for(input int n);
		if (n > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// result checker, compares each output beat with the oldest prediction
	always @(posedge clk) begin
		normal_t got;
		normal_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[47:32],
				m_axis_tdata[63:48], m_axis_tuser, m_axis_tlast};
			n_out++;
			if (got.degen) n_degen++;
			if (normal_q.size() == 0) begin
				$display("%0t: unexpected beat, actual %h", $time, got);
				n_err++;
			end else begin
				want = normal_q.pop_front();
				if (got.tag !== want.tag)
					$display("%0t: face_tag_out expected %h actual %h", $time, want.tag, got.tag);
				if (got.nx !== want.nx)
					$display("%0t: normal_x expected %h actual %h", $time, want.nx, got.nx);
				if (got.ny !== want.ny)
					$display("%0t: normal_y expected %h actual %h", $time, want.ny, got.ny);
				if (got.nz !== want.nz)
					$display("%0t: normal_z expected %h actual %h", $time, want.nz, got.nz);
				if (got.degen !== want.degen)
					$display("%0t: degenerate expected %b actual %b", $time, want.degen,
						got.degen);
				if (got.last !== want.last)
					$display("%0t: last_face_out expected %b actual %b", $time, want.last,
						got.last);
				if (got !== want) n_err++;
			end
		end
	end

	// predictions are queued on the accepting edge
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			normal_q.push_back(face_normal(s_axis_tdata, s_axis_tlast));
	end

	// receiver stalls at random, with calm stretches
	always @(posedge clk) begin
		int g;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (hold_rx) begin
			m_axis_tready <= 1'b1;
		end else begin
			g = $urandom_range(0, 99);
			if (((cyc / 2000) % 3) == 0) m_axis_tready <= 1'b1;
			else if (g < 4) m_axis_tready <= 1'b0;
			else if (g < 30) m_axis_tready <= ~m_axis_tready;
			else m_axis_tready <= 1'b1;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		normal_t nz;
		normal_t dg;
		logic [159:0] d;
		n_err = 0;
		n_out = 0;
		n_degen = 0;
		n_in = 0;
		hold_rx = 0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		nz = '0;

		// directed table: degenerate and unit z rows typed in, others predicted
		dg = '0;
		dg.degen = 1'b1;
		dg.tag = 16'h0000;
		add_row('0, 1'b0, 1, dg);                              // all corners at origin
		dg.tag = 16'hffff; dg.last = 1'b1;
		add_row(pack_face(16'hffff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
			16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff), 1'b1, 1, dg); // coincident corners
		dg.tag = 16'h1234; dg.last = 1'b0;
		add_row(pack_face(16'h1234, 0, 0, 0, 16'h1000, 16'h1000, 16'h1000,
			16'h2000, 16'h2000, 16'h2000), 1'b0, 1, dg);         // collinear corners
		nz = '0; nz.tag = 16'h0001; nz.nz = 16'd16384;
		add_row(pack_face(16'h0001, 0, 0, 0, 16'h1000, 0, 0, 0, 16'h1000, 0),
			1'b0, 1, nz);                                        // unit +z face
		nz = '0; nz.tag = 16'h0002; nz.nz = -16'sd16384; nz.last = 1'b1;
		add_row(pack_face(16'h0002, 0, 0, 0, 0, 16'h1000, 0, 16'h1000, 0, 0),
			1'b1, 1, nz);                                        // unit -z face
		add_row(pack_face(16'h0003, 0, 0, 0, 0, 16'h1000, 0, 0, 0, 16'h1000), 1'b0, 0, nz);
		add_row(pack_face(16'h0004, 0, 0, 0, 0, 0, 16'h1000, 16'h1000, 0, 0), 1'b0, 0, nz);
		// widest edges, both signs
		add_row(pack_face(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
			16'h8000, 16'h8000, 16'h7fff, 16'h8000), 1'b0, 0, nz);
		add_row(pack_face(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
			16'h7fff, 16'h7fff, 16'h8000, 16'h8000), 1'b1, 0, nz);
		add_row(pack_face(16'haaaa, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
			16'h7fff, 16'h8000, 16'h8000, 16'h7fff), 1'b0, 0, nz);
		// smallest nonzero cross products
		add_row(pack_face(16'h5555, 0, 0, 0, 1, 0, 0, 0, 1, 0), 1'b0, 0, nz);
		add_row(pack_face(16'h0f0f, 16'hffff, 16'hffff, 16'hffff, 0, 16'hffff, 16'hffff,
			16'hffff, 16'hffff, 0), 1'b1, 0, nz);
		add_row(pack_face(16'h00ff, 0, 0, 0, 16'h0003, 16'h0001, 16'h0002,
			16'h0001, 16'h0005, 16'h0007), 1'b0, 0, nz);          // tilted face

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].chk) begin
				normal_t p;
				p = face_normal(rows[i].data, rows[i].last);
				if (p !== rows[i].want) begin
					$display("%0t: table row %0d expected %h actual %h", $time, i,
						rows[i].want, p);
					n_err++;
				end
			end
			send_face(rows[i].data, rows[i].last);
			idle_for(gap_len());
		end

		for (int k = 0; k < N_RANDOM; k++) begin
			int kind;
			logic [15:0] c[9];
			kind = $urandom_range(0, 19);
			foreach (c[j]) c[j] = rand_coord();
			if (kind == 0) begin
				for (int j = 0; j < 3; j++) c[3 + j] = c[j];     // b equals a
			end else if (kind == 1) begin
				for (int j = 0; j < 3; j++) c[6 + j] = c[3 + j]; // c equals b
			end
			d = pack_face(16'($urandom()), c[0], c[1], c[2], c[3], c[4], c[5], c[6], c[7],
				c[8]);
			send_face(d, 1'($urandom_range(0, 1)));
			idle_for(gap_len());
			// sender drains the whole pipe once midway
			if (k == N_RANDOM / 2) begin
				s_axis_tvalid <= 1'b0;
				@(posedge clk);
				while (normal_q.size() != 0) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b0;
		hold_rx = 1;

		while (normal_q.size() != 0) @(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);

		$display("faces sent %0d, normals checked %0d, degenerate %0d", n_in, n_out, n_degen);
		$display("covered extreme corners, degenerate faces and random stalls on both sides");
		if (n_err == 0 && normal_q.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== triangle_face_normal.f =====
rtl/core/tfn_pkg.sv
rtl/core/tfn_cross.sv
rtl/core/tfn_norm.sv
rtl/core/tfn_sqrt.sv
rtl/core/tfn_div.sv
rtl/core/triangle_face_normal.sv
tb/tb.sv
